// ===== src/protobuf_stream_parser_assert.svh =====
// Assertion macros for the protobuf stream parser.
`ifndef PROTOBUF_STREAM_PARSER_ASSERT_SVH
`define PROTOBUF_STREAM_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define PSP_ASSERT(lbl, cond) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
else $error("parser assertion failed");
// Check that one condition implies another at the same edge.
`define PSP_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("parser implication failed");
`else
`define PSP_ASSERT(lbl, cond)
`define PSP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== src/pbsp_pkg.sv =====
// Types and constants shared by the protobuf stream parser modules.
package pbsp_pkg;

	localparam int VARINT_MAX = 10;
	localparam logic [6:0] PAYLOAD_MASK = 7'h7F;
	localparam logic [7:0] TOP_TAG_MAX = 8'hff;

	typedef enum logic [1:0] {
		ACT_BYTE    = 2'd0,
		ACT_RESET   = 2'd1,
		ACT_CONSUME = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		PH_STOPPED   = 4'd0,
		PH_VERSION   = 4'd1,
		PH_TOP_TAG   = 4'd2,
		PH_TOP_LEN   = 4'd3,
		PH_FIELD_TAG = 4'd5,
		PH_VARINT    = 4'd6,
		PH_DATA_LEN  = 4'd7,
		PH_DATA      = 4'd8,
		PH_EVENT     = 4'd9
	} phase_t;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_OVERRUN  = 3'd1;
	localparam logic [2:0] ERR_TOP_TAG  = 3'd2;
	localparam logic [2:0] ERR_WIRE     = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW = 3'd4;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LEN    = 3'd2;

	localparam logic [1:0] MK_NONE      = 2'd0;
	localparam logic [1:0] MK_HEARTBEAT = 2'd1;
	localparam logic [1:0] MK_LOGIN     = 2'd2;
	localparam logic [1:0] MK_STANZA    = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic [1:0]         event_kind;
		logic signed [31:0] event_value;
		logic               data_valid;
		logic [7:0]         data_out;
		logic [7:0]         field_number;
		logic [2:0]         nest_depth;
		logic [2:0]         error_kind;
		logic               halted;
	} result_t;

	typedef struct packed {
		logic [31:0] acc;
		logic        hi;
		logic [3:0]  cnt;
		logic        done;
		logic        overrun;
	} varint_t;

endpackage

// ===== src/pbsp_varint.sv =====
// Varint accumulator step: folds one byte into the running value.
module pbsp_varint
	import pbsp_pkg::*;
(
	input  logic [31:0] acc,
	input  logic        hi,
	input  logic [3:0]  cnt,
	input  logic [7:0]  rx_byte,
	output varint_t     vi
);
	logic [63:0] contrib;
	logic        hi_add;

	always_comb begin
		contrib = 64'(rx_byte[6:0] & PAYLOAD_MASK) << (7 * 32'(cnt));
		case (cnt) inside
			4'd0: hi_add = 1'b0;
			4'd1: hi_add = |rx_byte[6:1];
			[4'd2:4'd8]: hi_add = |rx_byte[6:0];
			4'd9: hi_add = rx_byte[0];
			default: hi_add = 1'b0;
		endcase
		// keep low word and a flag for anything at or above bit eight
		vi.acc     = acc | contrib[31:0];
		vi.hi      = hi | hi_add | (|contrib[31:8]);
		vi.cnt     = cnt + 4'd1;
		vi.done    = !rx_byte[7];
		vi.overrun = rx_byte[7] && (32'(vi.cnt) >= VARINT_MAX);
	end
endmodule

// ===== src/protobuf_stream_parser.sv =====
// Protobuf stream parser top level: input register, decode logic, result register.
//
// Decodes a length-prefixed protobuf message stream one beat at a time. Each
// accepted beat (a received byte, a connection reset or an event consume)
// yields exactly one result beat via the input register and the result
// register, and a new beat is taken every cycle unless the output stalls: the
// input register feeds one pass of decode logic that updates all parser state
// and loads the result register, which acts as the output skid stage. Sustained
// rate is one beat per cycle; the only stall is res_ready held low with both
// stages full. The decode pass tests every stack level's byte count in parallel,
// so any number of levels close in one beat. Bytes sent while halted or while an
// event is pending come back with accepted low and change nothing; a connection
// reset beat restarts the parser at the version varint.
module protobuf_stream_parser
	import pbsp_pkg::*;
#(
	parameter int MAX_NEST = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);
`include "protobuf_stream_parser_assert.svh"

	localparam int LCW = $clog2(MAX_NEST + 1);
	localparam int IW  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

	// input stage
	logic    s1_valid_q;
	item_t   item_s1;
	logic    advance;

	// parser state
	phase_t      ph_q, ph_n;
	logic [31:0] acc_q, acc_n;
	logic        hi_q, hi_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [31:0] bt_q, bt_n;
	logic [LCW-1:0] lc_q, lc_n, lc_fin;
	logic [7:0]  cf_q, cf_n;
	logic [31:0] fl_q, fl_n;
	logic [31:0] fdb_q, fdb_n;
	logic [1:0]  mk_q, mk_n;
	logic [1:0]  pk_q, pk_n;
	logic [31:0] pv_q, pv_n;
	logic [2:0]  err_q, err_n;

	logic [7:0]  ltag_q   [MAX_NEST];
	logic [31:0] llen_q   [MAX_NEST];
	logic [31:0] lstart_q [MAX_NEST];
	logic [7:0]  ltag_n   [MAX_NEST];
	logic [31:0] llen_n   [MAX_NEST];
	logic [31:0] lstart_n [MAX_NEST];
	logic [MAX_NEST-1:0] lvl_done;

	varint_t vi;
	result_t res_n;
	logic    acc_byte, is_data, test, data_chk, sub, popping;

	assign advance    = s1_valid_q && (!res_valid || res_ready);
	assign item_ready = !s1_valid_q || advance;

	pbsp_varint u_varint (
		.acc     (acc_q),
		.hi      (hi_q),
		.cnt     (cnt_q),
		.rx_byte (item_s1.rx_byte),
		.vi      (vi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		ph_n  = ph_q;   acc_n = acc_q; hi_n = hi_q; cnt_n = cnt_q;
		bt_n  = bt_q;   lc_n  = lc_q;  cf_n = cf_q; fl_n  = fl_q;
		fdb_n = fdb_q;  mk_n  = mk_q;  pk_n = pk_q; pv_n  = pv_q;
		err_n = err_q;
		ltag_n = ltag_q; llen_n = llen_q; lstart_n = lstart_q;
		acc_byte = 1'b0; is_data = 1'b0; test = 1'b0; data_chk = 1'b0;
		sub = 1'b0; popping = 1'b1; lc_fin = '0;

		unique case (action_t'(item_s1.action))
			ACT_BYTE: begin
				if (ph_q != PH_STOPPED && ph_q != PH_EVENT) begin
					acc_byte = 1'b1;
					bt_n = bt_q + 32'd1;
					if (ph_q == PH_DATA) begin
						// pass payload through and count it
						fdb_n    = fdb_q + 32'd1;
						is_data  = 1'b1;
						data_chk = 1'b1;
					end else if (vi.overrun) begin
						err_n = ERR_OVERRUN;
						ph_n  = PH_STOPPED;
						acc_n = '0; hi_n = 1'b0; cnt_n = '0;
					end else if (!vi.done) begin
						acc_n = vi.acc; hi_n = vi.hi; cnt_n = vi.cnt;
					end else begin
						acc_n = '0; hi_n = 1'b0; cnt_n = '0;
						unique case (ph_q)
							PH_VERSION: ph_n = PH_TOP_TAG;
							PH_TOP_TAG: begin
								if (vi.hi || vi.acc > 32'(TOP_TAG_MAX)) begin
									err_n = ERR_TOP_TAG;
									ph_n  = PH_STOPPED;
								end else begin
									pk_n      = MK_NONE;
									ltag_n[0] = vi.acc[7:0];
									ph_n      = PH_TOP_LEN;
								end
							end
							PH_TOP_LEN: begin
								llen_n[0]   = vi.acc;
								lstart_n[0] = bt_n;
								lc_n        = LCW'(1);
								case (ltag_q[0])
									8'd1: begin mk_n = MK_HEARTBEAT; pv_n = '0; end
									8'd3: begin mk_n = MK_LOGIN; pv_n = '0; end
									8'd8: mk_n = MK_STANZA;
									default: mk_n = MK_NONE;
								endcase
								test = 1'b1;
							end
							PH_FIELD_TAG: begin
								cf_n = vi.acc[10:3];
								if (vi.acc[2:0] == WT_VARINT) begin
									ph_n = PH_VARINT;
								end else if (vi.acc[2:0] == WT_LEN) begin
									ph_n = PH_DATA_LEN;
								end else begin
									err_n = ERR_WIRE;
									ph_n  = PH_STOPPED;
								end
							end
							PH_VARINT: begin
								if (mk_q == MK_LOGIN && lc_q == LCW'(2) && ltag_q[0] == 8'd3
								    && ltag_q[1] == 8'd3 && cf_q == 8'd1)
									pv_n = vi.acc;
								if (mk_q == MK_HEARTBEAT && lc_q == LCW'(1) && cf_q == 8'd2)
									pv_n = vi.acc;
								test = 1'b1;
							end
							PH_DATA_LEN: begin
								fl_n = vi.acc;
								if (mk_q == MK_LOGIN)
									sub = (lc_q == LCW'(1) && ltag_q[0] == 8'd3 &&
									       (cf_q == 8'd3 || cf_q == 8'd4 || cf_q == 8'd7)) ||
									      (lc_q == LCW'(2) && ltag_q[0] == 8'd3 &&
									       ltag_q[1] == 8'd3 && cf_q == 8'd4);
								else if (mk_q == MK_STANZA)
									sub = lc_q == LCW'(1) && ltag_q[0] == 8'd8 && cf_q == 8'd7;
								if (sub) begin
									if (32'(lc_q) >= MAX_NEST) begin
										err_n = ERR_OVERFLOW;
										ph_n  = PH_STOPPED;
									end else begin
										// push a new level
										llen_n[lc_q[IW-1:0]]   = vi.acc;
										ltag_n[lc_q[IW-1:0]]   = cf_q;
										lstart_n[lc_q[IW-1:0]] = bt_n;
										lc_n = lc_q + LCW'(1);
										test = 1'b1;
									end
								end else begin
									ph_n     = PH_DATA;
									fdb_n    = '0;
									data_chk = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			ACT_RESET: begin
				err_n = ERR_NONE;
				lc_n  = '0;
				ph_n  = PH_VERSION;
				acc_n = '0; hi_n = 1'b0; cnt_n = '0;
			end
			ACT_CONSUME: begin
				if (ph_q == PH_EVENT) begin
					ph_n  = PH_TOP_TAG;
					acc_n = '0; hi_n = 1'b0; cnt_n = '0;
				end
			end
			default: ;
		endcase

		if (data_chk && fdb_n >= fl_n)
			test = 1'b1;

		// close finished levels from the top down, stopping at the first open one
		for (int i = 0; i < MAX_NEST; i++)
			lvl_done[i] = (bt_n - lstart_n[i]) >= llen_n[i];
		lc_fin = lc_n;
		for (int i = MAX_NEST - 1; i >= 0; i--) begin
			if (LCW'(i) < lc_n && popping) begin
				if (lvl_done[i]) lc_fin = LCW'(i);
				else popping = 1'b0;
			end
		end

		if (test) begin
			acc_n = '0; hi_n = 1'b0; cnt_n = '0;
			if (lc_n == '0) begin
				ph_n = PH_TOP_TAG;
			end else if (lc_fin == '0) begin
				if (mk_n != MK_NONE) pk_n = mk_n;
				lc_n = '0;
				ph_n = (pk_n != MK_NONE) ? PH_EVENT : PH_TOP_TAG;
			end else begin
				lc_n = lc_fin;
				ph_n = PH_FIELD_TAG;
			end
		end

		res_n.accepted     = acc_byte;
		res_n.event_kind   = (ph_n == PH_EVENT) ? pk_n : MK_NONE;
		res_n.event_value  = (res_n.event_kind == MK_HEARTBEAT ||
		                      res_n.event_kind == MK_LOGIN) ? pv_n : '0;
		res_n.data_valid   = is_data;
		res_n.data_out     = is_data ? item_s1.rx_byte : '0;
		res_n.field_number = cf_n;
		res_n.nest_depth   = 3'(lc_n);
		res_n.error_kind   = err_n;
		res_n.halted       = ph_n == PH_STOPPED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_STOPPED; acc_q <= '0; hi_q <= 1'b0; cnt_q <= '0;
			bt_q <= '0; lc_q <= '0; cf_q <= '0; fl_q <= '0; fdb_q <= '0;
			mk_q <= MK_NONE; pk_q <= MK_NONE; pv_q <= '0; err_q <= ERR_NONE;
		end else if (advance) begin
			ph_q <= ph_n; acc_q <= acc_n; hi_q <= hi_n; cnt_q <= cnt_n;
			bt_q <= bt_n; lc_q <= lc_n; cf_q <= cf_n; fl_q <= fl_n; fdb_q <= fdb_n;
			mk_q <= mk_n; pk_q <= pk_n; pv_q <= pv_n; err_q <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ltag_q   <= ltag_n;
			llen_q   <= llen_n;
			lstart_q <= lstart_n;
			res      <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	`PSP_ASSERT(a_depth_bound, 32'(lc_q) <= MAX_NEST)
	`PSP_ASSERT_IMP(a_data_accepted, res_valid && res.data_valid, res.accepted && !res.halted)
	`PSP_ASSERT_IMP(a_event_blocks, ph_q == PH_EVENT, pk_q != MK_NONE && lc_q == '0)
endmodule

// ===== verif/protobuf_stream_parser_tb.sv =====
// Self-checking testbench for the protobuf stream parser.
module protobuf_stream_parser_tb;
	import pbsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	// Field-close check step; the RTL has no encoding for it, the predictor needs one.
	localparam logic [3:0] CLOSE_CHECK = 4'd4;
	localparam int NEST_LIMIT = 4;
	localparam int RANDOM_BEATS = 1800;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    res_valid;
	logic    res_ready = 1'b0;
	result_t res;

	item_t   stim_q[$];
	result_t parse_results_q[$];
	int      send_idle_pct = 22;
	int      recv_idle_pct = 65;
	logic    send_hold = 1'b0;
	int      fail_count = 0;

	// Parser image kept by the predictor.
	logic [3:0]  ph;
	logic [63:0] acc;
	int          vcnt;
	logic [31:0] total;
	logic [7:0]  ltag[NEST_LIMIT];
	logic [31:0] llen[NEST_LIMIT];
	logic [31:0] lstart[NEST_LIMIT];
	int          lcnt;
	logic [7:0]  fld;
	logic [31:0] flen;
	logic [31:0] fdone;
	logic [1:0]  mkind;
	logic [1:0]  pkind;
	logic [31:0] pval;
	logic [2:0]  errc;

	protobuf_stream_parser #(.MAX_NEST(NEST_LIMIT)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #5 clk = ~clk;

	function automatic void goto_phase(logic [3:0] p);
		ph = p;
		acc = '0;
		vcnt = 0;
	endfunction

	function automatic void halt_with(logic [2:0] code);
		errc = code;
		goto_phase(PH_STOPPED);
	endfunction

	function automatic logic opens_level();
		if (mkind == MK_LOGIN)
			return (lcnt == 1 && ltag[0] == 8'd3 &&
				(fld == 8'd3 || fld == 8'd4 || fld == 8'd7)) ||
				(lcnt == 2 && ltag[0] == 8'd3 && ltag[1] == 8'd3 && fld == 8'd4);
		if (mkind == MK_STANZA)
			return lcnt == 1 && ltag[0] == 8'd8 && fld == 8'd7;
		return 1'b0;
	endfunction

	// Close finished data fields and any levels whose byte count is reached.
	function automatic void close_levels();
		int top;
		forever begin
			if (ph == PH_DATA && fdone >= flen) begin
				goto_phase(CLOSE_CHECK);
			end else if (ph == CLOSE_CHECK) begin
				if (lcnt == 0 || lcnt > NEST_LIMIT) begin
					goto_phase(PH_TOP_TAG);
					return;
				end
				top = lcnt - 1;
				if (total - lstart[top] >= llen[top]) begin
					if (lcnt == 1 && mkind != MK_NONE)
						pkind = mkind;
					lcnt--;
					if (lcnt == 0) begin
						goto_phase(pkind != MK_NONE ? PH_EVENT : PH_TOP_TAG);
						return;
					end
				end else begin
					goto_phase(PH_FIELD_TAG);
					return;
				end
			end else begin
				return;
			end
		end
	endfunction

	// Consume one stream byte; returns 1 when it was field payload.
	function automatic logic parse_byte(logic [7:0] b);
		logic done;
		total++;
		if (ph == PH_DATA) begin
			fdone++;
			close_levels();
			return 1'b1;
		end
		if (vcnt < VARINT_MAX)
			acc |= 64'(b & 8'h7F) << (7 * vcnt);
		vcnt++;
		done = !b[7];
		if (!done && vcnt >= VARINT_MAX) begin
			halt_with(ERR_OVERRUN);
			return 1'b0;
		end
		if (!done)
			return 1'b0;
		case (ph)
			PH_VERSION: begin
				goto_phase(PH_TOP_TAG);
			end
			PH_TOP_TAG: begin
				if (acc > 64'hff) begin
					halt_with(ERR_TOP_TAG);
					return 1'b0;
				end
				pkind = MK_NONE;
				ltag[0] = acc[7:0];
				goto_phase(PH_TOP_LEN);
			end
			PH_TOP_LEN: begin
				llen[0] = acc[31:0];
				lstart[0] = total;
				lcnt = 1;
				case (ltag[0])
					8'd1: begin
						mkind = MK_HEARTBEAT;
						pval = '0;
					end
					8'd3: begin
						mkind = MK_LOGIN;
						pval = '0;
					end
					8'd8: mkind = MK_STANZA;
					default: mkind = MK_NONE;
				endcase
				goto_phase(CLOSE_CHECK);
			end
			PH_FIELD_TAG: begin
				fld = acc[10:3];
				if (acc[2:0] == WT_VARINT)
					goto_phase(PH_VARINT);
				else if (acc[2:0] == WT_LEN)
					goto_phase(PH_DATA_LEN);
				else begin
					halt_with(ERR_WIRE);
					return 1'b0;
				end
			end
			PH_VARINT: begin
				if (mkind == MK_LOGIN && lcnt == 2 && ltag[0] == 8'd3 &&
						ltag[1] == 8'd3 && fld == 8'd1)
					pval = acc[31:0];
				if (mkind == MK_HEARTBEAT && lcnt == 1 && fld == 8'd2)
					pval = acc[31:0];
				goto_phase(CLOSE_CHECK);
			end
			PH_DATA_LEN: begin
				flen = acc[31:0];
				if (opens_level()) begin
					if (lcnt >= NEST_LIMIT) begin
						halt_with(ERR_OVERFLOW);
						return 1'b0;
					end
					llen[lcnt] = flen;
					ltag[lcnt] = fld;
					lstart[lcnt] = total;
					lcnt++;
					goto_phase(CLOSE_CHECK);
				end else begin
					goto_phase(PH_DATA);
					fdone = '0;
				end
			end
			default: ;
		endcase
		close_levels();
		return 1'b0;
	endfunction

	function automatic result_t predict_parse(item_t it);
		result_t r;
		logic    is_data;
		r = '0;
		is_data = 1'b0;
		case (it.action)
			ACT_BYTE: begin
				if (ph != PH_STOPPED && ph != PH_EVENT) begin
					r.accepted = 1'b1;
					is_data = parse_byte(it.rx_byte);
				end
			end
			ACT_RESET: begin
				errc = ERR_NONE;
				lcnt = 0;
				goto_phase(PH_VERSION);
			end
			ACT_CONSUME: begin
				if (ph == PH_EVENT)
					goto_phase(PH_TOP_TAG);
			end
			default: ;
		endcase
		r.event_kind = (ph == PH_EVENT) ? pkind : MK_NONE;
		r.event_value = (r.event_kind == MK_HEARTBEAT || r.event_kind == MK_LOGIN) ? pval : '0;
		r.data_valid = is_data;
		r.data_out = is_data ? it.rx_byte : 8'h00;
		r.field_number = fld;
		r.nest_depth = lcnt[2:0];
		r.error_kind = errc;
		r.halted = (ph == PH_STOPPED);
		return r;
	endfunction

	function automatic void put_varint(ref byte_q_t q, input logic [63:0] v);
		logic [7:0] b;
		do begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			if (v != 0)
				b[7] = 1'b1;
			q.push_back(b);
		end while (v != 0);
	endfunction

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v >> $urandom_range(63, 0);
	endfunction

	// Build a message body; fields the schema names become nested bodies.
	function automatic void make_body(ref byte_q_t q, input logic [1:0] mk, input int cnt,
			input logic [7:0] t0, input logic [7:0] t1);
		byte_q_t sub;
		int      nf;
		int      f;
		logic    nested;
		nf = $urandom_range(4, 0);
		for (int i = 0; i < nf; i++) begin
			case ($urandom_range(6, 0))
				0: f = 1;
				1: f = 2;
				2: f = 3;
				3: f = 4;
				4: f = 7;
				5: f = $urandom_range(300, 0);
				default: f = $urandom_range(15, 0);
			endcase
			if ($urandom_range(1, 0) == 0) begin
				put_varint(q, 64'({f, WT_VARINT}));
				put_varint(q, rand_value());
			end else begin
				nested = (mk == MK_LOGIN &&
					((cnt == 1 && t0 == 8'd3 && (f == 3 || f == 4 || f == 7)) ||
					(cnt == 2 && t0 == 8'd3 && t1 == 8'd3 && f == 4))) ||
					(mk == MK_STANZA && cnt == 1 && t0 == 8'd8 && f == 7);
				sub.delete();
				if (nested)
					make_body(sub, mk, cnt + 1, t0, (cnt == 1) ? 8'(f) : t1);
				else
					repeat ($urandom_range(6, 0)) sub.push_back(8'($urandom));
				put_varint(q, 64'({f, WT_LEN}));
				put_varint(q, 64'(sub.size()));
				foreach (sub[k])
					q.push_back(sub[k]);
			end
		end
	endfunction

	function automatic void queue_beat(logic [1:0] a, logic [7:0] b);
		item_t it;
		it.action = a;
		it.rx_byte = b;
		stim_q.push_back(it);
	endfunction

	function automatic void queue_bytes(byte_q_t q);
		foreach (q[k])
			queue_beat(ACT_BYTE, q[k]);
	endfunction

	function automatic void queue_message(int tag);
		byte_q_t body;
		byte_q_t msg;
		logic [1:0] mk;
		mk = (tag == 1) ? MK_HEARTBEAT : (tag == 3) ? MK_LOGIN : (tag == 8) ? MK_STANZA : MK_NONE;
		make_body(body, mk, 1, 8'(tag), 8'd0);
		put_varint(msg, 64'(tag));
		put_varint(msg, 64'(body.size()));
		foreach (body[k])
			msg.push_back(body[k]);
		queue_bytes(msg);
		queue_beat(ACT_CONSUME, 8'($urandom));
	endfunction

	function automatic void queue_connect();
		byte_q_t v;
		queue_beat(ACT_RESET, 8'($urandom));
		put_varint(v, rand_value());
		queue_bytes(v);
	endfunction

	function automatic void fill_stimulus();
		int pick;
		// Refused while stopped after power-up, consume with nothing pending, unused action.
		queue_beat(ACT_BYTE, 8'hA5);
		queue_beat(ACT_CONSUME, 8'h00);
		queue_beat(ACT_NONE, 8'hFF);
		queue_beat(ACT_RESET, 8'h00);
		queue_bytes('{8'h81, 8'h01});
		// Heartbeat with stream id 0xFFFFFFFF, then a byte refused while it is pending.
		queue_bytes('{8'h01, 8'h06, 8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F});
		queue_beat(ACT_BYTE, 8'h00);
		queue_beat(ACT_CONSUME, 8'h00);
		// Empty stanza closes at once; then a login with an empty data field.
		queue_bytes('{8'h08, 8'h00});
		queue_beat(ACT_CONSUME, 8'h00);
		queue_bytes('{8'h03, 8'h07, 8'h1A, 8'h03, 8'h08, 8'h7F, 8'h12, 8'h00, 8'h00});
		queue_beat(ACT_CONSUME, 8'h00);
		// Top tag too big, then bad wire type after a reconnect.
		queue_bytes('{8'h80, 8'h02});
		queue_beat(ACT_RESET, 8'h00);
		queue_bytes('{8'h00, 8'h05, 8'h02, 8'h09});
		// Varint overrun: ten continuation bytes.
		queue_connect();
		repeat (10) queue_beat(ACT_BYTE, 8'hFF);

		queue_connect();
		while (stim_q.size() < RANDOM_BEATS) begin
			pick = $urandom_range(99, 0);
			if (pick < 10) begin
				repeat ($urandom_range(4, 1))
					queue_beat(2'($urandom_range(3, 0)), 8'($urandom));
				queue_connect();
			end else if (pick < 35) begin
				queue_message(3);
			end else if (pick < 55) begin
				queue_message(1);
			end else if (pick < 75) begin
				queue_message(8);
			end else begin
				queue_message($urandom_range(255, 0));
			end
		end
	endfunction

	// Feed beats; hold the payload until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && item_ready)
				parse_results_q.push_back(predict_parse(item));
			if (item_valid && !item_ready) begin
				// hold
			end else if (stim_q.size() != 0 && !send_hold &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				item_valid <= 1'b1;
				item <= stim_q.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Check each result beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			if (res_valid && res_ready) begin
				if (parse_results_q.size() == 0) begin
					$error("result beat with no prediction waiting");
					fail_count++;
				end else begin
					want = parse_results_q.pop_front();
					if (res.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, res.accepted);
						fail_count++;
					end
					if (res.event_kind !== want.event_kind) begin
						$error("event_kind: expected %0d, got %0d",
							want.event_kind, res.event_kind);
						fail_count++;
					end
					if (res.event_value !== want.event_value) begin
						$error("event_value: expected %0d, got %0d",
							want.event_value, res.event_value);
						fail_count++;
					end
					if (res.data_valid !== want.data_valid) begin
						$error("data_valid: expected %0d, got %0d",
							want.data_valid, res.data_valid);
						fail_count++;
					end
					if (res.data_out !== want.data_out) begin
						$error("data_out: expected %0h, got %0h", want.data_out, res.data_out);
						fail_count++;
					end
					if (res.field_number !== want.field_number) begin
						$error("field_number: expected %0d, got %0d",
							want.field_number, res.field_number);
						fail_count++;
					end
					if (res.nest_depth !== want.nest_depth) begin
						$error("nest_depth: expected %0d, got %0d",
							want.nest_depth, res.nest_depth);
						fail_count++;
					end
					if (res.error_kind !== want.error_kind) begin
						$error("error_kind: expected %0d, got %0d",
							want.error_kind, res.error_kind);
						fail_count++;
					end
					if (res.halted !== want.halted) begin
						$error("halted: expected %0d, got %0d", want.halted, res.halted);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		int total_beats;
		ph = PH_STOPPED;
		acc = '0;
		vcnt = 0;
		total = '0;
		lcnt = 0;
		fld = '0;
		flen = '0;
		fdone = '0;
		mkind = MK_NONE;
		pkind = MK_NONE;
		pval = '0;
		errc = ERR_NONE;
		foreach (ltag[k]) begin
			ltag[k] = '0;
			llen[k] = '0;
			lstart[k] = '0;
		end
		fill_stimulus();
		total_beats = stim_q.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Swap idle rates after a third, then stop idling.
		wait (stim_q.size() < total_beats * 2 / 3);
		send_idle_pct = 65;
		recv_idle_pct = 22;
		wait (stim_q.size() < total_beats / 2);
		// Drain the pipeline fully before sending more.
		send_hold = 1'b1;
		wait (!item_valid && parse_results_q.size() == 0);
		@(posedge clk);
		send_hold = 1'b0;
		wait (stim_q.size() < total_beats / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		wait (stim_q.size() == 0 && !item_valid && parse_results_q.size() == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && parse_results_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
